// File: hw/rtl/ssob_pkg.sv
// ----------------------------------------------------------------------------
// ssob_pkg: shared types for the sell side order book
// Operation codes, status codes, controller states and fixed widths.
// ----------------------------------------------------------------------------
package ssob_pkg;

  localparam int ArrivalW = 32;

  typedef enum logic [1:0] {
    OpAdd   = 2'd0,
    OpTake  = 2'd1,
    OpClear = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    StRested  = 3'd0,
    StMatched = 3'd1,
    StTaken   = 3'd2,
    StEmpty   = 3'd3,
    StFull    = 3'd4,
    StCleared = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle = 3'b001,
    FsmFree = 3'b010,
    FsmScan = 3'b100
  } fsm_e;

endpackage

// File: hw/rtl/sell_side_order_book_top.sv
// ----------------------------------------------------------------------------
// sell_side_order_book_top: sell side of a price-time priority order book
// Resting orders live in a RAM; a controller searches it for takes.
// ----------------------------------------------------------------------------
// Usage. A command beat is accepted at a rising edge where start_i is high and
// busy_o is low. Each command produces exactly one result beat, shown for one
// cycle with done_o high; the receiver cannot stall and must take it then.
// An add that matches the buy side, an add to a full book, a clear, a take
// from an empty book and an unused operation code finish at once: the
// result appears in the cycle after acceptance.
// An add that rests searches the valid bits for the lowest free slot, one slot
// per cycle, and writes the order into the first free slot that it finds.
// A take sweeps the whole slot RAM through its single read port, one entry per
// cycle, picking the cheapest, oldest order and the next lowest price in the
// same pass: each address is issued in turn, the registered read data of each
// entry is compared as it returns, and a final step retires the pick.
// busy_o falls in the cycle the result is shown, so a new command may be
// accepted while done_o is high.
// Reset clears the valid bits, the arrival counter and the order count at
// once and sets the best price to all ones; the RAM itself is not cleared,
// since only the data of valid slots is ever used.
// ----------------------------------------------------------------------------
module sell_side_order_book_top #(
  parameter int BOOK_CAPACITY = 256,
  parameter int PRICE_BITS    = 32,
  parameter int TAG_BITS      = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         operation_i,
  input  logic [PRICE_BITS-1:0]              sell_price_i,
  input  logic [TAG_BITS-1:0]                order_tag_i,
  input  logic [PRICE_BITS-1:0]              buy_best_price_i,
  input  logic                               buy_nonempty_i,
  output logic                               done_o,
  output ssob_pkg::status_e                  status_o,
  output logic [TAG_BITS-1:0]                out_tag_o,
  output logic [PRICE_BITS-1:0]              out_price_o,
  output logic [PRICE_BITS-1:0]              best_price_o,
  output logic [$clog2(BOOK_CAPACITY+1)-1:0] resting_count_o
);
  import ssob_pkg::*;

  localparam int IdxW  = $clog2(BOOK_CAPACITY);
  localparam int CntW  = $clog2(BOOK_CAPACITY + 1);
  localparam int WordW = ArrivalW + TAG_BITS + PRICE_BITS;
  localparam logic [IdxW:0]   IdxEnd = (IdxW+1)'(BOOK_CAPACITY);
  localparam logic [CntW-1:0] CntMax = CntW'(BOOK_CAPACITY);

  // Control state.
  fsm_e                  fsm_q, fsm_d;
  logic [BOOK_CAPACITY-1:0] valid_q, valid_d;
  logic [ArrivalW-1:0]   arr_q, arr_d;
  logic [PRICE_BITS-1:0] lowest_q, lowest_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  done_q, done_d;
  logic [IdxW:0]         rd_idx_q, rd_idx_d;
  logic                  pend_q, pend_d;
  logic                  have_q, have_d;

  // Payload registers.
  logic [PRICE_BITS-1:0] price_q, price_d;
  logic [TAG_BITS-1:0]   tag_q, tag_d;
  logic [IdxW-1:0]       pend_idx_q, pend_idx_d;
  logic [PRICE_BITS-1:0] bprice_q, bprice_d;
  logic [ArrivalW-1:0]   bage_q, bage_d;
  logic [IdxW-1:0]       bidx_q, bidx_d;
  logic [TAG_BITS-1:0]   btag_q, btag_d;
  logic [PRICE_BITS-1:0] oth_q, oth_d;
  status_e               status_q, status_d;
  logic [TAG_BITS-1:0]   otag_q, otag_d;
  logic [PRICE_BITS-1:0] oprice_q, oprice_d;

  // RAM ports.
  logic                  we;
  logic [IdxW-1:0]       waddr, raddr;
  logic [WordW-1:0]      wdata, rdata;
  logic [PRICE_BITS-1:0] e_price;
  logic [TAG_BITS-1:0]   e_tag;
  logic [ArrivalW-1:0]   e_age;
  logic                  take_new;

  ssob_ram #(
    .WIDTH(WordW),
    .DEPTH(BOOK_CAPACITY)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Fields of the entry read in the previous cycle.
  assign e_price = rdata[PRICE_BITS-1:0];
  assign e_tag   = rdata[PRICE_BITS +: TAG_BITS];
  assign e_age   = arr_q - rdata[PRICE_BITS+TAG_BITS +: ArrivalW];
  // A strictly older order at the same price wins, so lower slots win ties.
  assign take_new = !have_q || (e_price < bprice_q) ||
                    ((e_price == bprice_q) && (e_age > bage_q));

  assign waddr = rd_idx_q[IdxW-1:0];
  assign wdata = {arr_q, tag_q, price_q};
  assign raddr = rd_idx_q[IdxW-1:0];

  always_comb begin
    fsm_d      = fsm_q;
    valid_d    = valid_q;
    arr_d      = arr_q;
    lowest_d   = lowest_q;
    count_d    = count_q;
    done_d     = 1'b0;
    rd_idx_d   = rd_idx_q;
    pend_d     = 1'b0;
    have_d     = have_q;
    price_d    = price_q;
    tag_d      = tag_q;
    pend_idx_d = pend_idx_q;
    bprice_d   = bprice_q;
    bage_d     = bage_q;
    bidx_d     = bidx_q;
    btag_d     = btag_q;
    oth_d      = oth_q;
    status_d   = status_q;
    otag_d     = otag_q;
    oprice_d   = oprice_q;
    we         = 1'b0;

    unique case (fsm_q)
      FsmIdle: begin
        if (start_i) begin
          price_d  = sell_price_i;
          tag_d    = order_tag_i;
          rd_idx_d = '0;
          otag_d   = '0;
          oprice_d = '0;
          case (op_e'(operation_i))
            OpAdd: begin
              if (buy_nonempty_i && (buy_best_price_i >= sell_price_i)) begin
                status_d = StMatched;
                otag_d   = order_tag_i;
                oprice_d = sell_price_i;
                done_d   = 1'b1;
              end else if (count_q >= CntMax) begin
                status_d = StFull;
                done_d   = 1'b1;
              end else begin
                fsm_d = FsmFree;
              end
            end
            OpTake: begin
              if (count_q == '0) begin
                status_d = StEmpty;
                lowest_d = '1;
                done_d   = 1'b1;
              end else begin
                have_d = 1'b0;
                oth_d  = '1;
                fsm_d  = FsmScan;
              end
            end
            OpClear: begin
              valid_d  = '0;
              arr_d    = '0;
              lowest_d = '1;
              count_d  = '0;
              status_d = StCleared;
              done_d   = 1'b1;
            end
            default: begin
              status_d = StFull;
              done_d   = 1'b1;
            end
          endcase
        end
      end

      FsmFree: begin
        // A free slot exists because the count is below capacity.
        if (!valid_q[rd_idx_q[IdxW-1:0]]) begin
          we                             = 1'b1;
          valid_d[rd_idx_q[IdxW-1:0]]    = 1'b1;
          arr_d                          = arr_q + ArrivalW'(1);
          count_d                        = count_q + CntW'(1);
          if (price_q < lowest_q) begin
            lowest_d = price_q;
          end
          status_d = StRested;
          done_d   = 1'b1;
          fsm_d    = FsmIdle;
        end else begin
          rd_idx_d = rd_idx_q + (IdxW+1)'(1);
        end
      end

      FsmScan: begin
        if (rd_idx_q != IdxEnd) begin
          rd_idx_d   = rd_idx_q + (IdxW+1)'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q[IdxW-1:0];
        end
        if (pend_q && valid_q[pend_idx_q]) begin
          // The runner-up minimum covers every valid entry but the final pick.
          if (take_new) begin
            if (have_q && (bprice_q < oth_q)) begin
              oth_d = bprice_q;
            end
            have_d   = 1'b1;
            bprice_d = e_price;
            bage_d   = e_age;
            bidx_d   = pend_idx_q;
            btag_d   = e_tag;
          end else if (e_price < oth_q) begin
            oth_d = e_price;
          end
        end
        if ((rd_idx_q == IdxEnd) && !pend_q) begin
          valid_d[bidx_q] = 1'b0;
          count_d         = count_q - CntW'(1);
          lowest_d        = oth_q;
          status_d        = StTaken;
          otag_d          = btag_q;
          oprice_d        = bprice_q;
          done_d          = 1'b1;
          fsm_d           = FsmIdle;
        end
      end

      default: begin
        fsm_d = FsmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q    <= FsmIdle;
      valid_q  <= '0;
      arr_q    <= '0;
      lowest_q <= '1;
      count_q  <= '0;
      done_q   <= 1'b0;
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      fsm_q    <= fsm_d;
      valid_q  <= valid_d;
      arr_q    <= arr_d;
      lowest_q <= lowest_d;
      count_q  <= count_d;
      done_q   <= done_d;
      rd_idx_q <= rd_idx_d;
      pend_q   <= pend_d;
      have_q   <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q    <= price_d;
    tag_q      <= tag_d;
    pend_idx_q <= pend_idx_d;
    bprice_q   <= bprice_d;
    bage_q     <= bage_d;
    bidx_q     <= bidx_d;
    btag_q     <= btag_d;
    oth_q      <= oth_d;
    status_q   <= status_d;
    otag_q     <= otag_d;
    oprice_q   <= oprice_d;
  end

  assign busy_o          = (fsm_q != FsmIdle);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign out_tag_o       = otag_q;
  assign out_price_o     = oprice_q;
  assign best_price_o    = lowest_q;
  assign resting_count_o = count_q;

  // The result beat is only shown once the controller has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result shown while busy");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax) else $error("order count above capacity");

  a_empty_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (lowest_q == '1)) else $error("empty book has a best price");

  a_take_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (operation_i == OpTake) && (count_q == '0))
      |=> (done_o && (status_o == StEmpty))) else $error("empty take not reported");

endmodule

// File: hw/rtl/ssob_ram.sv
// ----------------------------------------------------------------------------
// ssob_ram: generic single write, single read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ssob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sell side order book
// Drives add, take, clear and unused commands with random gaps. A local book
// model predicts every result beat, and each beat is checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import ssob_pkg::*;

  localparam int Cap      = 256;
  localparam int CntW     = 9;
  localparam int CycleCap = 2500000;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    status_e         status;
    logic [15:0]     tag;
    logic [31:0]     price;
    logic [31:0]     best;
    logic [CntW-1:0] count;
  } book_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] op = OpAdd;
  logic [31:0] sell_price = '0;
  logic [15:0] order_tag = '0;
  logic [31:0] buy_best = '0;
  logic buy_nonempty = 1'b0;
  logic busy;
  logic done;
  status_e status;
  logic [15:0] out_tag;
  logic [31:0] out_price;
  logic [31:0] best_price;
  logic [CntW-1:0] resting_count;

  // Local copy of the book contents.
  logic        bk_valid [Cap];
  logic [31:0] bk_price [Cap];
  logic [15:0] bk_tag   [Cap];
  logic [31:0] bk_stamp [Cap];
  logic [31:0] bk_arrivals;
  logic [31:0] bk_lowest;
  int unsigned bk_count;

  book_result_t pending_results[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;

  sell_side_order_book_top i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .operation_i      (op),
    .sell_price_i     (sell_price),
    .order_tag_i      (order_tag),
    .buy_best_price_i (buy_best),
    .buy_nonempty_i   (buy_nonempty),
    .done_o           (done),
    .status_o         (status),
    .out_tag_o        (out_tag),
    .out_price_o      (out_price),
    .best_price_o     (best_price),
    .resting_count_o  (resting_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Clearing the model also serves as its reset.
  function automatic void book_clear();
    for (int i = 0; i < Cap; i++) begin
      bk_valid[i] = 1'b0;
    end
    bk_arrivals = '0;
    bk_lowest   = '1;
    bk_count    = 0;
  endfunction

  // Applies one command to the local book and returns the result beat the
  // block should produce for it.
  function automatic book_result_t book_apply(logic [1:0] cmd, logic [31:0] px,
                                              logic [15:0] tg, logic [31:0] bb,
                                              logic bne);
    book_result_t r;
    int slot;
    int pick;
    logic [31:0] age;
    logic [31:0] pick_age;
    r.status = StFull;
    r.tag    = '0;
    r.price  = '0;
    slot     = -1;
    pick     = -1;
    pick_age = '0;
    case (cmd)
      OpAdd: begin
        if (bne && bb >= px) begin
          r.status = StMatched;
          r.tag    = tg;
          r.price  = px;
        end else if (bk_count < Cap) begin
          for (int i = Cap - 1; i >= 0; i--) begin
            if (!bk_valid[i]) slot = i;
          end
          bk_valid[slot] = 1'b1;
          bk_price[slot] = px;
          bk_tag[slot]   = tg;
          bk_stamp[slot] = bk_arrivals;
          bk_arrivals    = bk_arrivals + 1;
          bk_count++;
          if (px < bk_lowest) bk_lowest = px;
          r.status = StRested;
        end
      end
      OpTake: begin
        // Cheapest first; among equal prices the oldest, then the lower slot.
        for (int i = 0; i < Cap; i++) begin
          if (bk_valid[i]) begin
            age = bk_arrivals - bk_stamp[i];
            if (pick < 0 || bk_price[i] < bk_price[pick] ||
                (bk_price[i] == bk_price[pick] && age > pick_age)) begin
              pick     = i;
              pick_age = age;
            end
          end
        end
        if (pick < 0) begin
          r.status  = StEmpty;
          bk_lowest = '1;
        end else begin
          r.status = StTaken;
          r.tag    = bk_tag[pick];
          r.price  = bk_price[pick];
          bk_valid[pick] = 1'b0;
          bk_count--;
          bk_lowest = '1;
          for (int i = 0; i < Cap; i++) begin
            if (bk_valid[i] && bk_price[i] < bk_lowest) bk_lowest = bk_price[i];
          end
        end
      end
      OpClear: begin
        book_clear();
        r.status = StCleared;
      end
      default: begin
      end
    endcase
    r.best  = bk_lowest;
    r.count = bk_count[CntW-1:0];
    return r;
  endfunction

  // Presents one command beat and holds it until the block accepts it. start
  // stays high on return; the gap task lowers it when a pause follows.
  task automatic send_command(logic [1:0] cmd, logic [31:0] px, logic [15:0] tg,
                              logic [31:0] bb, logic bne);
    start        <= 1'b1;
    op           <= cmd;
    sell_price   <= px;
    order_tag    <= tg;
    buy_best     <= bb;
    buy_nonempty <= bne;
    do @(posedge clk); while (busy);
    pending_results.push_back(book_apply(cmd, px, tg, bb, bne));
  endtask

  // Random pause between beats: mostly none or short, now and then long.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 45) n = 0;
    else if (n < 93) n = $urandom_range(1, 4);
    else n = $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Pause the sender until every outstanding result beat has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic add_order(logic [31:0] px, logic [15:0] tg);
    send_command(OpAdd, px, tg, '0, 1'b0);
    idle_gap();
  endtask

  task automatic take_order();
    send_command(OpTake, $urandom, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
    idle_gap();
  endtask

  // Empty book, matching rules, price and tag extremes, time priority,
  // clear and the unused operation code.
  task automatic test_directed();
    take_order();
    send_command(OpAdd, 32'd100, 16'hFFFF, 32'd100, 1'b1);
    send_command(OpAdd, 32'd100, 16'h0001, 32'd99, 1'b1);
    send_command(OpAdd, 32'd100, 16'h0002, 32'hFFFF_FFFF, 1'b0);
    send_command(OpAdd, 32'd0, 16'h0000, 32'hFFFF_FFFF, 1'b1);
    add_order(32'hFFFF_FFFF, 16'hFFFF);
    add_order(32'd100, 16'h0003);
    add_order(32'd50, 16'hA5A5);
    send_command(OpUnused, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    repeat (4) take_order();
    // Only the all-ones price remains, so best price equals the empty mark.
    take_order();
    take_order();
    add_order(32'h5A5A_5A5A, 16'h5A5A);
    add_order(32'h5A5A_5A5A, 16'h1234);
    send_command(OpClear, '1, '1, '1, 1'b1);
    take_order();
    add_order(32'd7, 16'd7);
    send_command(OpClear, '0, '0, '0, 1'b0);
    drain_results();
  endtask

  // Fill every slot, get refused, match on a full book, then take forty out, add forty back and clear.
  task automatic test_full_book();
    for (int i = 0; i < Cap; i++) begin
      send_command(OpAdd, $urandom_range(0, 15), i[15:0], '0, 1'b0);
    end
    send_command(OpAdd, 32'd3, 16'hBEEF, 32'd2, 1'b1);
    send_command(OpAdd, 32'd3, 16'hBEEF, 32'd3, 1'b1);
    idle_gap();
    for (int i = 0; i < 40; i++) take_order();
    for (int i = 0; i < 40; i++) add_order($urandom_range(0, 15), 16'($urandom));
    drain_results();
    send_command(OpClear, '0, '0, '0, 1'b0);
    drain_results();
  endtask

  // Mostly well-formed traffic on a living book; prices come from narrow
  // ranges so equal-price ties are common, with some full-range noise.
  task automatic test_random_traffic(int unsigned beats, int unsigned add_weight);
    logic [31:0] px;
    logic [31:0] bb;
    int sel;
    for (int unsigned k = 0; k < beats; k++) begin
      sel = $urandom_range(0, 99);
      px  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1000, 1031);
      bb  = ($urandom_range(0, 1) == 0) ? px + $urandom_range(0, 2) - 1 : $urandom;
      if (sel < add_weight)
        send_command(OpAdd, px, 16'($urandom), bb, $urandom_range(0, 2) == 0);
      else if (sel < 96)
        send_command(OpTake, px, 16'($urandom), bb, 1'($urandom_range(0, 1)));
      else if (sel < 98)
        send_command(OpUnused, px, 16'($urandom), bb, 1'($urandom_range(0, 1)));
      else
        send_command(OpClear, px, 16'($urandom), bb, 1'($urandom_range(0, 1)));
      idle_gap();
      if (k % 300 == 299) drain_results();
    end
  endtask

  // Each result beat is compared with the oldest expectation.
  always @(posedge clk) begin
    book_result_t want;
    if (rst_n && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d tag=%h price=%h best=%h count=%0d",
                 $time, status, out_tag, out_price, best_price, resting_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          error_count++;
        end
        if (out_tag !== want.tag) begin
          $display("%0t: out_tag expected %h actual %h", $time, want.tag, out_tag);
          error_count++;
        end
        if (out_price !== want.price) begin
          $display("%0t: out_price expected %h actual %h", $time, want.price, out_price);
          error_count++;
        end
        if (best_price !== want.best) begin
          $display("%0t: best_price expected %h actual %h", $time, want.best, best_price);
          error_count++;
        end
        if (resting_count !== want.count) begin
          $display("%0t: resting_count expected %0d actual %0d",
                   $time, want.count, resting_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung block ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleCap) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    book_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_book();
    // Add-heavy traffic drives the book toward full; balanced traffic follows.
    test_random_traffic(600, 75);
    test_random_traffic(1100, 50);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sell_side_order_book_top.f
hw/rtl/ssob_pkg.sv
hw/rtl/ssob_ram.sv
hw/rtl/sell_side_order_book_top.sv
tb/sv/tb.sv
